### sv/udf_pkg.sv
// Shared constants, types and helpers for the unsigned decimal formatter.
package udf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_FIELD_DEF  = 63;

  // Lengths are carried in 8 bits so MAX_FIELD may go up to 255.
  localparam int LEN_W  = 8;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  localparam logic [1:0] MODE_RIGHT = 2'd0;
  localparam logic [1:0] MODE_ZERO  = 2'd1;
  localparam logic [1:0] MODE_LEFT  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  body;
    logic [LEN_W-1:0]  padn;
    logic              pad_left;
    logic [CHAR_W-1:0] padc;
  } layout_t;

  // Decimal digits needed for a binary value of the given width.
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

### sv/udf_dabble.sv
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
module udf_dabble #(
  parameter int VALUE_BITS = udf_pkg::VALUE_BITS_DEF,
  parameter int NDIG       = udf_pkg::dec_digits(udf_pkg::VALUE_BITS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [NDIG*4-1:0]     bcd
);
  import udf_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [NDIG*4-1:0]     adj;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      {bcd, bin} <= {adj[NDIG*4-2:0], bin, 1'b0};
    end
  end

endmodule

### sv/udf_emit.sv
// Character emitter: walks the field one character per output transaction.
module udf_emit #(
  parameter int NDIG = udf_pkg::dec_digits(udf_pkg::VALUE_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  udf_pkg::layout_t layout,
  input  logic [NDIG*4-1:0] bcd,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_char, [13:8] total_length
  output logic             m_tlast,
  output logic             done
);
  import udf_pkg::*;

  localparam int IDX_W = $clog2(NDIG);

  layout_t          lay;
  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] r;
  logic             in_pad;
  logic [3:0]       digit;
  logic [CHAR_W-1:0] ch;
  logic             xfer;

  assign xfer = m_tvalid && m_tready;

  always_comb begin
    if (lay.pad_left) begin
      in_pad = k < lay.padn;
      r      = lay.total - 1'b1 - k;
    end else begin
      in_pad = k >= lay.body;
      r      = lay.body - 1'b1 - k;
    end
    // Positions above the converter's digits are leading zeros.
    if (r < LEN_W'(NDIG)) begin
      digit = bcd[r[IDX_W-1:0]*4 +: 4];
    end else begin
      digit = 4'd0;
    end
    ch = in_pad ? lay.padc : (ASCII_ZERO | {4'd0, digit});
  end

  assign m_tlast = (k == lay.total - 1'b1);
  assign m_tdata = {2'b00, lay.total[5:0], ch};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      done     <= 1'b0;
      k        <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        m_tvalid <= 1'b1;
        k        <= '0;
      end else if (xfer) begin
        if (m_tlast) begin
          m_tvalid <= 1'b0;
          done     <= 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lay <= layout;
    end
  end

endmodule

### sv/unsigned_decimal_formatter.sv
// Top level of the printf-style unsigned decimal (%u) formatter.
//
// Input stream (s_*): one transaction per number, carrying the value, the
// field width, the precision (negative = not given) and the pad mode.
// Output stream (m_*): one transaction per ASCII character of the field,
// with tlast on the final character and the field length in every item.
//
// Operation: one number is converted to BCD by a shift-and-add-3 unit that
// handles one value bit per cycle, then ST_SIZE sizes the field from the
// digits and the emitter offers the first character. The characters follow
// one per cycle while m_tready holds high. A field of length zero gives no
// output transaction at all.
//
// s_tready is high only while the block is idle; the next number is taken
// once the last character of the previous one has been accepted. A stall on
// m_tready holds the current character and freezes the emitter.
// Reset (rst, synchronous) returns to idle and drops any field in flight.
module unsigned_decimal_formatter #(
  parameter int VALUE_BITS = udf_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD  = udf_pkg::MAX_FIELD_DEF,
  localparam int S_W       = ((VALUE_BITS + 15 + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  // [VALUE_BITS-1:0] value, then field_width (6), digit_precision (7),
  // pad_mode (2), zero fill to whole bytes
  input  logic [S_W-1:0] s_tdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,  // [7:0] out_char, [13:8] total_length
  output logic           m_tlast
);
  import udf_pkg::*;

  localparam int NDIG = dec_digits(VALUE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [5:0]        width;
  logic [5:0]        prec;
  logic              prec_given;
  logic [1:0]        mode;
  logic              zero_case;

  logic              accept;
  logic              conv_done;
  logic              emit_done;
  logic              emit_start;
  logic [NDIG*4-1:0] bcd;
  logic [LEN_W-1:0]  ndig;
  logic [LEN_W-1:0]  width_cap;
  logic [LEN_W-1:0]  prec_cap;
  logic [LEN_W-1:0]  body_raw;
  logic [LEN_W-1:0]  total_raw;
  layout_t           layout;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      width      <= s_tdata[VALUE_BITS +: 6];
      prec       <= s_tdata[VALUE_BITS+6 +: 6];
      prec_given <= !s_tdata[VALUE_BITS+12];
      mode       <= s_tdata[VALUE_BITS+13 +: 2];
      zero_case  <= (s_tdata[VALUE_BITS-1:0] == '0) && !s_tdata[VALUE_BITS+12] &&
                    (s_tdata[VALUE_BITS+6 +: 6] == 6'd0);
    end
  end

  udf_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (s_tdata[VALUE_BITS-1:0]),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // Significant digit count; zero still shows one digit unless suppressed.
  always_comb begin
    ndig = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        ndig = LEN_W'(i + 1);
      end
    end
    if (zero_case) begin
      ndig = '0;
    end else if (ndig == '0) begin
      ndig = LEN_W'(1);
    end
  end

  always_comb begin
    width_cap = ({2'b00, width} > MAX_LEN) ? MAX_LEN : {2'b00, width};
    prec_cap  = prec_given ? {2'b00, prec} : '0;
    if (prec_cap > MAX_LEN) begin
      prec_cap = MAX_LEN;
    end
    body_raw  = (prec_cap > ndig) ? prec_cap : ndig;
    layout.body = (body_raw > MAX_LEN) ? MAX_LEN : body_raw;
    total_raw = (width_cap > layout.body) ? width_cap : layout.body;
    layout.total    = (total_raw > MAX_LEN) ? MAX_LEN : total_raw;
    layout.padn     = layout.total - layout.body;
    layout.pad_left = (mode != MODE_LEFT);
    layout.padc     = (mode == MODE_ZERO && !prec_given) ? ASCII_ZERO : ASCII_SPACE;
  end

  assign emit_start = (state == ST_SIZE) && (layout.total != '0);

  udf_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (emit_start),
    .layout   (layout),
    .bcd      (bcd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .done     (emit_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CONV;
      ST_CONV: if (conv_done) state_next = ST_SIZE;
      ST_SIZE: state_next = emit_start ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (emit_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a field is being emitted");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output continued after the last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready stayed high after an input transaction");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] != 6'd0))
    else $error("character emitted for a field of length zero");

endmodule
